// ===== rtl/daimd_pkg.sv =====
`timescale 1ns / 1ps
package daimd_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [15:0] FIXED_WINDOW = 16'd50;
    localparam logic [15:0] DT_MAX_WINDOW = 16'd1000;
    localparam logic [15:0] RESET_WINDOW = 16'd15;
    localparam logic [15:0] WIN_MAX = 16'hFFFF;

    localparam logic [2:0] MODE_FIXED = 3'd0;
    localparam logic [2:0] MODE_DELAY = 3'd1;
    localparam logic [2:0] MODE_AIMD = 3'd2;
    localparam logic [2:0] MODE_PAIMD = 3'd3;
    localparam logic [2:0] MODE_DOUBLE = 3'd4;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_EXPIRY = 3'd1;
    localparam logic [2:0] REG_HOLDOFF = 3'd2;
    localparam logic [2:0] REG_MODULUS = 3'd3;
    localparam logic [2:0] REG_FACTOR = 3'd4;
    localparam logic [2:0] REG_TARGET = 3'd5;
    localparam logic [2:0] REG_LOW = 3'd6;
    localparam logic [2:0] REG_HIGH = 3'd7;

    typedef struct packed {
        logic        command;
        logic [31:0] seq_number;
        logic [31:0] event_time;
        logic [31:0] acked_send_time;
        logic [30:0] random_draw;
    } in_item_t;

    typedef struct packed {
        logic [15:0] window;
        logic        cut_applied;
        logic        table_overflow;
    } out_item_t;

    // divider request / reply between the top level and the divide unit
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/daimd_if.sv =====
`timescale 1ns / 1ps
interface daimd_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/daimd_div.sv =====
`timescale 1ns / 1ps
module daimd_div (
    input  logic             clk,
    input  logic             rst_n,
    input  daimd_pkg::div_req_t req,
    output daimd_pkg::div_rsp_t rsp
);
    import daimd_pkg::*;

    // restoring divide, one quotient bit per cycle
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[47]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[46:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = trial - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

// ===== rtl/daimd_table.sv =====
`timescale 1ns / 1ps
module daimd_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [daimd_pkg::IDX_W-1:0]    rd_addr,
    output logic [31:0]                    rd_seq,
    output logic [31:0]                    rd_time,
    output logic                           rd_valid,
    input  logic                           wr_en,
    input  logic [daimd_pkg::IDX_W-1:0]    wr_addr,
    input  logic [31:0]                    wr_seq,
    input  logic [31:0]                    wr_time,
    input  logic                           vld_set,
    input  logic                           vld_clr,
    input  logic [daimd_pkg::IDX_W-1:0]    vld_addr
);
    import daimd_pkg::*;

    logic [63:0] mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [63:0] rd_reg;
    logic        rdv_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_seq, wr_time};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            if (vld_clr)
            begin
                valid_reg[vld_addr] <= 1'b0;
            end
            if (vld_set)
            begin
                valid_reg[vld_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rdv_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_seq   = rd_reg[63:32];
    assign rd_time  = rd_reg[31:0];
    assign rd_valid = rdv_reg;

endmodule

// ===== rtl/delay_aimd_congestion_window_unit.sv =====
`timescale 1ns / 1ps
// one transaction in, one transaction out; sequential, one event at a time
// send: one table-memory read per slot, 64 slots, plus a cut step when a cut applies
// ack: one table pass (modes 2, 3) and a serial divider where the mode needs one;
// fixed and unused modes skip both the table pass and the divider
// reset: window 15, all slots invalid (valid flops), times 0, registers at defaults
module delay_aimd_congestion_window_unit (
    input  logic        clk,
    input  logic        rst_n,
    daimd_if.sink       in_ch,
    daimd_if.source     out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import daimd_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_SEND  = 4'd2;
    localparam logic [3:0] ST_CUT   = 4'd3;
    localparam logic [3:0] ST_ACK   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_MOD   = 4'd6;
    localparam logic [3:0] ST_DIVW  = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // configuration registers
    logic [2:0]  mode_reg;
    logic [31:0] expiry_reg, holdoff_reg, target_reg;
    logic [30:0] modulus_reg;
    logic [15:0] factor_reg, low_reg, high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_PAIMD;
            expiry_reg  <= 32'd51;
            holdoff_reg <= 32'd74;
            modulus_reg <= 31'd5205;
            factor_reg  <= 16'd15073;
            target_reg  <= 32'd3428;
            low_reg     <= 16'd30;
            high_reg    <= 16'd70;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[2:0];
                REG_EXPIRY:  expiry_reg  <= cfg_data;
                REG_HOLDOFF: holdoff_reg <= cfg_data;
                REG_MODULUS: modulus_reg <= cfg_data[30:0];
                REG_FACTOR:  factor_reg  <= cfg_data[15:0];
                REG_TARGET:  target_reg  <= cfg_data;
                REG_LOW:     low_reg     <= cfg_data[15:0];
                REG_HIGH:    high_reg    <= cfg_data[15:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    // control and state registers
    logic [3:0]        st_reg, st_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;      // read pointer, one ahead of compare
    logic              rdv_pipe_reg, rdv_pipe_next;
    logic [IDX_W-1:0]  cmp_reg, cmp_next;      // slot whose data sits on the read port
    logic              dup_reg, dup_next;
    logic              exp_reg, exp_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              cut_reg, cut_next;
    logic              ovf_reg, ovf_next;
    logic [15:0]       win_reg, win_next;
    logic [31:0]       lcut_reg, lcut_next;
    logic [31:0]       ladj_reg, ladj_next;
    in_item_t          item_reg, item_next;
    logic [31:0]       prod_reg, prod_next;    // mult and square scratch
    logic              ovl_reg, ovl_next;      // square above 32 bits
    logic              ovalid_reg, ovalid_next;
    out_item_t         odata_reg, odata_next;
    logic              divmode_reg, divmode_next; // 1 when dividing for window

    // table
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [31:0]       rd_seq, rd_time;
    logic              rd_valid;
    logic              wr_en, vld_set, vld_clr;
    logic [IDX_W-1:0]  vld_addr;

    daimd_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_seq   (rd_seq),
        .rd_time  (rd_time),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (vld_addr),
        .wr_seq   (item_reg.seq_number),
        .wr_time  (item_reg.event_time),
        .vld_set  (vld_set),
        .vld_clr  (vld_clr),
        .vld_addr (vld_addr)
    );

    // divider, used for the window scale and the draw modulo
    div_req_t dreq;
    div_rsp_t drsp;

    daimd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // derived values of the held event
    logic [31:0] rtt, div_rtt, dcut, age;
    logic [15:0] win_inc;
    logic [31:0] r_val;
    logic [47:0] q;
    logic [48:0] wq;
    logic [31:0] sq_cap;

    assign rtt     = item_reg.event_time - item_reg.acked_send_time;
    assign div_rtt = (rtt == 32'd0) ? 32'd1 : rtt;
    assign dcut    = item_reg.event_time - lcut_reg;
    assign age     = item_reg.event_time - rd_time;
    assign win_inc = (win_reg == WIN_MAX) ? WIN_MAX : win_reg + 16'd1;
    assign q       = drsp.quotient;
    assign sq_cap  = (ovl_reg || prod_reg > target_reg) ? target_reg : prod_reg;

    assign in_ch.ready = (st_reg == ST_IDLE) && !ovalid_reg;
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = odata_reg;

    always_comb
    begin
        st_next       = st_reg;
        idx_next      = idx_reg;
        rdv_pipe_next = 1'b0;
        cmp_next      = cmp_reg;
        dup_next      = dup_reg;
        exp_next      = exp_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cut_next      = cut_reg;
        ovf_next      = ovf_reg;
        win_next      = win_reg;
        lcut_next     = lcut_reg;
        ladj_next     = ladj_reg;
        item_next     = item_reg;
        prod_next     = prod_reg;
        ovl_next      = ovl_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        divmode_next  = divmode_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        vld_set       = 1'b0;
        vld_clr       = 1'b0;
        vld_addr      = cmp_reg;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = div_rtt;
        r_val         = '0;
        wq            = '0;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    item_next = in_ch.payload;
                    dup_next  = 1'b0;
                    exp_next  = 1'b0;
                    free_next = 1'b0;
                    cut_next  = 1'b0;
                    ovf_next  = 1'b0;
                    idx_next  = '0;
                    if (!in_ch.payload.command)
                    begin
                        if (mode_reg == MODE_DELAY || mode_reg == MODE_AIMD
                            || mode_reg == MODE_PAIMD)
                            st_next = ST_SCAN;
                        else
                            st_next = ST_OUT;
                    end
                    else if (mode_reg == MODE_AIMD || mode_reg == MODE_PAIMD)
                    begin
                        st_next = ST_ACK;
                    end
                    else
                    begin
                        st_next = ST_ACK;
                        idx_next = CNT_W'(TABLE_ENTRIES);
                    end
                end
            end

            // send: read every slot, free expired ones, note duplicate and lowest free; ack: clear the acked slot
            ST_SCAN, ST_ACK:
            begin
                if (idx_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    rd_en         = 1'b1;
                    rdv_pipe_next = 1'b1;
                    cmp_next      = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                if (rdv_pipe_reg)
                begin
                    if (st_reg == ST_SCAN)
                    begin
                        if (rd_valid && rd_seq == item_reg.seq_number)
                            dup_next = 1'b1;
                        if (rd_valid && age > expiry_reg)
                        begin
                            vld_clr  = 1'b1;
                            exp_next = 1'b1;
                        end
                        if ((!rd_valid || age > expiry_reg) && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = cmp_reg;
                        end
                    end
                    else if (rd_valid && rd_seq == item_reg.seq_number && !dup_reg)
                    begin
                        vld_clr  = 1'b1;
                        dup_next = 1'b1;
                    end
                end
                if (!rdv_pipe_reg && idx_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    st_next = (st_reg == ST_SCAN) ? ST_SEND : ST_SQ;
                    if (st_reg == ST_ACK)
                        prod_next = dcut;
                end
            end

            ST_SEND:
            begin
                if (!dup_reg)
                begin
                    if (free_reg)
                    begin
                        vld_addr = free_idx_reg;
                        wr_en    = 1'b1;
                        vld_set  = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (exp_reg && dcut > holdoff_reg)
                begin
                    lcut_next = item_reg.event_time;
                    if (mode_reg == MODE_AIMD || mode_reg == MODE_PAIMD)
                    begin
                        prod_next = 32'(win_reg) * 32'(factor_reg);
                        st_next   = ST_CUT;
                    end
                    else
                        st_next = ST_OUT;
                end
                else
                begin
                    if (lcut_reg == 32'd0)
                        lcut_next = item_reg.event_time;
                    st_next = ST_OUT;
                end
            end

            ST_CUT:
            begin
                win_next = (prod_reg[31:16] == 16'd0) ? 16'd1 : prod_reg[31:16];
                cut_next = 1'b1;
                st_next  = ST_OUT;
            end

            // ack: square d (prod_reg holds d), then update the window or go on to the needed divide
            ST_SQ:
            begin
                {ovl_next, prod_next} = {1'b0, 32'd0};
                if (prod_reg[31:16] != 16'd0)
                    ovl_next = 1'b1;
                else
                    prod_next = prod_reg * prod_reg;
                st_next = ST_MOD;
                if (mode_reg == MODE_AIMD)
                begin
                    win_next = win_inc;
                    st_next  = ST_OUT;
                end
                else if (mode_reg == MODE_DELAY)
                begin
                    if (rtt < 32'(high_reg))
                    begin
                        win_next = win_inc;
                        st_next  = ST_OUT;
                    end
                    else
                    begin
                        st_next = ST_MUL;
                    end
                end
                else if (mode_reg == MODE_DOUBLE)
                begin
                    if ((item_reg.event_time - ladj_reg) > 32'd1)
                    begin
                        ladj_next = item_reg.event_time;
                        if (rtt < 32'(low_reg) || rtt >= 32'(high_reg))
                            st_next = ST_MUL;
                        else
                        begin
                            win_next = (win_inc > DT_MAX_WINDOW) ? DT_MAX_WINDOW
                                                                 : win_inc;
                            st_next = ST_OUT;
                        end
                    end
                    else
                        st_next = ST_OUT;
                end
                else if (mode_reg != MODE_PAIMD)
                begin
                    st_next = ST_OUT;
                end
            end

            ST_MOD:
            begin
                if (modulus_reg == 31'd0)
                begin
                    st_next = ST_DIVW;
                    divmode_next = 1'b0;
                    // no reduction: compare at once via a divide by 1 skipped
                    if ({1'b0, item_reg.random_draw} > sq_cap)
                        win_next = win_inc;
                    st_next = ST_OUT;
                end
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 48'(item_reg.random_draw);
                    dreq.divisor  = 32'(modulus_reg);
                    divmode_next  = 1'b0;
                    st_next       = ST_DIVW;
                end
            end

            ST_MUL:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = (mode_reg == MODE_DOUBLE && rtt < 32'(low_reg))
                                ? 48'(32'(win_reg) * 32'(low_reg))
                                : 48'(32'(win_reg) * 32'(high_reg));
                divmode_next  = 1'b1;
                st_next       = ST_DIVW;
            end

            ST_DIVW:
            begin
                if (drsp.done)
                begin
                    st_next = ST_OUT;
                    if (!divmode_reg)
                    begin
                        r_val = drsp.remainder;
                        if (r_val > sq_cap)
                            win_next = win_inc;
                    end
                    else if (mode_reg == MODE_DOUBLE)
                    begin
                        wq = {1'b0, q} + ((rtt < 32'(low_reg)) ? 49'd1 : 49'd0);
                        if (wq == 49'd0)
                            win_next = 16'd1;
                        else if (wq > 49'(DT_MAX_WINDOW))
                            win_next = DT_MAX_WINDOW;
                        else
                            win_next = wq[15:0];
                    end
                    else
                    begin
                        win_next = (q == 48'd0) ? 16'd1 : q[15:0];
                    end
                end
            end

            ST_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next.window = (mode_reg == MODE_FIXED) ? FIXED_WINDOW : win_reg;
                    odata_next.cut_applied    = cut_reg;
                    odata_next.table_overflow = ovf_reg;
                    st_next = ST_IDLE;
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            idx_reg      <= '0;
            rdv_pipe_reg <= 1'b0;
            win_reg      <= RESET_WINDOW;
            lcut_reg     <= '0;
            ladj_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            idx_reg      <= idx_next;
            rdv_pipe_reg <= rdv_pipe_next;
            win_reg      <= win_next;
            lcut_reg     <= lcut_next;
            ladj_reg     <= ladj_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg      <= cmp_next;
        dup_reg      <= dup_next;
        exp_reg      <= exp_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        cut_reg      <= cut_next;
        ovf_reg      <= ovf_next;
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        ovl_reg      <= ovl_next;
        odata_reg    <= odata_next;
        divmode_reg  <= divmode_next;
    end

endmodule

// ===== rtl/daimd_checker.sv =====
`timescale 1ns / 1ps
module daimd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_window,
    input logic        out_cut,
    input logic        out_ovf
);
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_window))
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken before result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_cut && out_ovf && out_window == 16'd0))
        else $error("impossible result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_cut |-> out_window != 16'd0)
        else $error("cut produced zero window");
endmodule

bind delay_aimd_congestion_window_unit daimd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_window (out_ch.payload.window),
    .out_cut    (out_ch.payload.cut_applied),
    .out_ovf    (out_ch.payload.table_overflow)
);

// ===== verif/tb_delay_aimd_congestion_window_unit.sv =====
`timescale 1ns / 1ps
module tb_delay_aimd_congestion_window_unit;
    import daimd_pkg::*;

    // run limit in clock cycles, several times the slowest legal run
    localparam int CYCLE_LIMIT = 3000000;
    // quiet time before a register write and at the end
    localparam int SETTLE_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    daimd_if #(.payload_t(in_item_t))  in_ch ();
    daimd_if #(.payload_t(out_item_t)) out_ch ();

    delay_aimd_congestion_window_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock: 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor state: our own copy of the registers and the block state
    // ------------------------------------------------------------------
    logic [2:0]  cur_mode;
    logic [31:0] cur_expiry;
    logic [31:0] cur_holdoff;
    logic [30:0] cur_modulus;
    logic [15:0] cur_factor;
    logic [31:0] cur_target;
    logic [15:0] cur_low;
    logic [15:0] cur_high;

    logic [15:0] win_now;
    bit          slot_busy [TABLE_ENTRIES];
    logic [31:0] slot_seqno [TABLE_ENTRIES];
    logic [31:0] slot_stamp [TABLE_ENTRIES];
    logic [31:0] last_cut;
    logic [31:0] last_adjust;

    // expected window results, oldest first
    out_item_t window_q[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  gap_next = 1;
    bit  no_idle = 1'b0;
    int  hold_req = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    // stimulus bookkeeping: clock in ms and packets still in flight
    logic [31:0] now_ms;
    logic [31:0] next_seq;
    logic [31:0] flight_seq[$];
    logic [31:0] flight_time[$];

    function automatic int find_slot(logic [31:0] seq);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_busy[i] && slot_seqno[i] == seq)
                return i;
        return -1;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] w);
        return (w == WIN_MAX) ? w : w + 16'd1;
    endfunction

    // works out the result of one event and advances the predictor state
    function automatic out_item_t predict_window(in_item_t it);
        out_item_t       r;
        logic [31:0]     rtt;
        logic [31:0]     dv;
        logic [31:0]     since_cut;
        longint unsigned w;
        longint unsigned sq;
        longint unsigned rr;
        int              k;
        bit              dup;
        bit              expired;
        r.cut_applied = 1'b0;
        r.table_overflow = 1'b0;
        if (!it.command)
        begin
            if (cur_mode == MODE_DELAY || cur_mode == MODE_AIMD || cur_mode == MODE_PAIMD)
            begin
                dup = (find_slot(it.seq_number) >= 0);
                expired = 1'b0;
                // expiry scan over every slot
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot_busy[i] && (it.event_time - slot_stamp[i]) > cur_expiry)
                    begin
                        slot_busy[i] = 1'b0;
                        expired = 1'b1;
                    end
                if (!dup)
                begin
                    k = -1;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            k = i;
                    if (k >= 0)
                    begin
                        slot_busy[k] = 1'b1;
                        slot_seqno[k] = it.seq_number;
                        slot_stamp[k] = it.event_time;
                    end
                    else
                        r.table_overflow = 1'b1;
                end
                if (expired && (it.event_time - last_cut) > cur_holdoff)
                begin
                    if (cur_mode == MODE_AIMD || cur_mode == MODE_PAIMD)
                    begin
                        w = (longint'(win_now) * longint'(cur_factor)) >> 16;
                        win_now = (w == 0) ? 16'd1 : w[15:0];
                        r.cut_applied = 1'b1;
                    end
                    last_cut = it.event_time;
                end
                else if (last_cut == 32'd0)
                    last_cut = it.event_time;
            end
        end
        else
        begin
            rtt = it.event_time - it.acked_send_time;
            dv = (rtt == 32'd0) ? 32'd1 : rtt;
            if (cur_mode == MODE_AIMD || cur_mode == MODE_PAIMD)
            begin
                k = find_slot(it.seq_number);
                if (k >= 0)
                    slot_busy[k] = 1'b0;
            end
            if (cur_mode == MODE_AIMD)
                win_now = bump(win_now);
            else if (cur_mode == MODE_PAIMD)
            begin
                since_cut = it.event_time - last_cut;
                sq = longint'(since_cut) * longint'(since_cut);
                rr = (cur_modulus == 31'd0) ? longint'(it.random_draw)
                                            : longint'(it.random_draw % cur_modulus);
                if (sq > longint'(cur_target))
                    sq = longint'(cur_target);
                if (rr > sq)
                    win_now = bump(win_now);
            end
            else if (cur_mode == MODE_DELAY)
            begin
                if (rtt < {16'd0, cur_high})
                    win_now = bump(win_now);
                else
                begin
                    w = longint'(win_now) * longint'(cur_high) / longint'(dv);
                    win_now = (w == 0) ? 16'd1 : w[15:0];
                end
            end
            else if (cur_mode == MODE_DOUBLE)
            begin
                // adjustment at most once per 2 ms
                if ((it.event_time - last_adjust) > 32'd1)
                begin
                    last_adjust = it.event_time;
                    if (rtt < {16'd0, cur_low})
                        w = longint'(win_now) * longint'(cur_low) / longint'(dv) + 1;
                    else if (rtt < {16'd0, cur_high})
                        w = longint'(win_now) + 1;
                    else
                        w = longint'(win_now) * longint'(cur_high) / longint'(dv);
                    if (w == 0)
                        w = 1;
                    if (w > longint'(DT_MAX_WINDOW))
                        w = longint'(DT_MAX_WINDOW);
                    win_now = w[15:0];
                end
            end
        end
        r.window = (cur_mode == MODE_FIXED) ? FIXED_WINDOW : win_now;
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic in_item_t make_event(bit cmd, logic [31:0] seq, logic [31:0] t,
                                            logic [31:0] sent, logic [30:0] draw);
        in_item_t it;
        it.command = cmd;
        it.seq_number = seq;
        it.event_time = t;
        it.acked_send_time = sent;
        it.random_draw = draw;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready, long hold-off on request, field checks
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (window_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: window %0d",
                           out_ch.payload.window);
                    mismatches++;
                end
                else
                begin
                    want = window_q.pop_front();
                    if (out_ch.payload.window !== want.window)
                    begin
                        $error("window: expected %0d, got %0d", want.window,
                               out_ch.payload.window);
                        mismatches++;
                    end
                    if (out_ch.payload.cut_applied !== want.cut_applied)
                    begin
                        $error("cut_applied: expected %0d, got %0d", want.cut_applied,
                               out_ch.payload.cut_applied);
                        mismatches++;
                    end
                    if (out_ch.payload.table_overflow !== want.table_overflow)
                    begin
                        $error("table_overflow: expected %0d, got %0d",
                               want.table_overflow, out_ch.payload.table_overflow);
                        mismatches++;
                    end
                end
            end
            // a requested hold-off is counted here, in cycles
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (no_idle)
                out_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
        else
            out_ch.ready <= 1'b0;
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one event and waits for its transaction; valid stays up when
    // the next event follows with no gap
    task automatic send_event(in_item_t it);
        repeat (gap_next) @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        window_q.push_back(predict_window(it));
        gap_next = no_idle ? 0 : pick_gap();
        if (gap_next > 0)
            in_ch.valid <= 1'b0;
    endtask

    // waits until every expected result is in and the block has gone quiet
    task automatic drain();
        if (gap_next == 0)
            in_ch.valid <= 1'b0;
        gap_next = 1;
        while (window_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MODE:    cur_mode = val[2:0];
            REG_EXPIRY:  cur_expiry = val;
            REG_HOLDOFF: cur_holdoff = val;
            REG_MODULUS: cur_modulus = val[30:0];
            REG_FACTOR:  cur_factor = val[15:0];
            REG_TARGET:  cur_target = val;
            REG_LOW:     cur_low = val[15:0];
            REG_HIGH:    cur_high = val[15:0];
            default:     ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [2:0] mode, logic [31:0] expiry, logic [31:0] holdoff,
                             logic [30:0] modulus, logic [15:0] factor, logic [31:0] target,
                             logic [15:0] low, logic [15:0] high);
        drain();
        write_reg(REG_MODE, {29'd0, mode});
        write_reg(REG_EXPIRY, expiry);
        write_reg(REG_HOLDOFF, holdoff);
        write_reg(REG_MODULUS, {1'b0, modulus});
        write_reg(REG_FACTOR, {16'd0, factor});
        write_reg(REG_TARGET, target);
        write_reg(REG_LOW, {16'd0, low});
        write_reg(REG_HIGH, {16'd0, high});
    endtask

    // one random event: mostly sends of fresh packets and acks of packets in
    // flight, with duplicates, stray acks and clock jumps mixed in
    task automatic random_event();
        int       r;
        int       k;
        in_item_t it;
        r = $urandom_range(0, 19);
        if (r < 2)
            now_ms = now_ms;
        else if (r < 17)
            now_ms = now_ms + $urandom_range(1, 20);
        else if (r < 19)
            now_ms = now_ms + $urandom_range(50, 300);
        else
            now_ms = $urandom;
        it.random_draw = 31'($urandom);
        it.acked_send_time = $urandom;
        if ($urandom_range(0, 1) == 0)
        begin
            it.command = 1'b0;
            it.event_time = now_ms;
            r = $urandom_range(0, 9);
            if (r < 7 || flight_seq.size() == 0)
            begin
                it.seq_number = next_seq;
                next_seq++;
            end
            else if (r < 9)
                it.seq_number = flight_seq[$urandom_range(0, flight_seq.size() - 1)];
            else
                it.seq_number = $urandom;
            flight_seq.push_back(it.seq_number);
            flight_time.push_back(now_ms);
            if (flight_seq.size() > 300)
            begin
                void'(flight_seq.pop_front());
                void'(flight_time.pop_front());
            end
        end
        else
        begin
            it.command = 1'b1;
            it.event_time = now_ms;
            if (flight_seq.size() > 0 && $urandom_range(0, 9) < 8)
            begin
                k = $urandom_range(0, flight_seq.size() - 1);
                it.seq_number = flight_seq[k];
                it.acked_send_time = flight_time[k];
                flight_seq.delete(k);
                flight_time.delete(k);
            end
            else
            begin
                it.seq_number = $urandom;
                if ($urandom_range(0, 1) == 0)
                    it.acked_send_time = now_ms - $urandom_range(0, 200);
            end
        end
        send_event(it);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings (probabilistic aimd): duplicates, stray ack, zero rtt,
    // expiry cut, field extremes and time wraparound
    task automatic test_reset_settings();
        send_event(make_event(1'b0, 32'd1, 32'd10, 32'd0, 31'd0));
        send_event(make_event(1'b0, 32'd2, 32'd20, 32'd0, 31'd0));
        send_event(make_event(1'b0, 32'd1, 32'd25, 32'd0, 31'd0));
        send_event(make_event(1'b1, 32'd1, 32'd30, 32'd10, 31'h7FFF_FFFF));
        send_event(make_event(1'b1, 32'd999, 32'd30, 32'd30, 31'd0));
        send_event(make_event(1'b0, 32'd3, 32'd200, 32'd0, 31'd0));
        send_event(make_event(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 31'h7FFF_FFFF));
        send_event(make_event(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        send_event(make_event(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 31'd0));
    endtask

    // aimd with nothing ever expiring: fill every slot, then two more, then free one and refill it
    task automatic test_table_full();
        write_all(MODE_AIMD, 32'hFFFF_FFFF, 32'd74, 31'd5205, 16'd15073, 32'd3428,
                  16'd30, 16'd70);
        for (int i = 0; i < TABLE_ENTRIES + 2; i++)
            send_event(make_event(1'b0, 32'd5000 + i, 32'd1000, 32'd0, 31'd0));
        send_event(make_event(1'b1, 32'd5003, 32'd1010, 32'd1000, 31'd0));
        send_event(make_event(1'b0, 32'd7000, 32'd1011, 32'd0, 31'd0));
    endtask

    // cut factors at both ends, delay modes on short and long rtt,
    // fixed and unused modes
    task automatic test_modes_directed();
        write_all(MODE_AIMD, 32'd1, 32'd1, 31'd0, 16'd1, 32'd1, 16'd0, 16'd1);
        send_event(make_event(1'b0, 32'd10, 32'd5000, 32'd0, 31'd0));
        send_event(make_event(1'b0, 32'd11, 32'd5010, 32'd0, 31'd0));
        write_all(MODE_PAIMD, 32'd1, 32'd1, 31'd0, 16'd65535, 32'hFFFF_FFFF,
                  16'd65535, 16'd65535);
        send_event(make_event(1'b1, 32'd11, 32'd5020, 32'd5010, 31'h7FFF_FFFF));
        send_event(make_event(1'b0, 32'd12, 32'd5030, 32'd0, 31'd0));
        write_all(MODE_DOUBLE, 32'd51, 32'd74, 31'd5205, 16'd15073, 32'd3428,
                  16'd30, 16'd70);
        send_event(make_event(1'b1, 32'd1, 32'd6000, 32'd6000, 31'd0));
        send_event(make_event(1'b1, 32'd1, 32'd6001, 32'd5990, 31'd0));
        send_event(make_event(1'b1, 32'd1, 32'd6010, 32'd5960, 31'd0));
        send_event(make_event(1'b1, 32'd1, 32'd6020, 32'd5000, 31'd0));
        write_all(MODE_DELAY, 32'd51, 32'd74, 31'd5205, 16'd15073, 32'd3428,
                  16'd30, 16'd70);
        send_event(make_event(1'b1, 32'd1, 32'd7000, 32'd6990, 31'd0));
        send_event(make_event(1'b1, 32'd1, 32'd7000, 32'd0, 31'd0));
        for (int m = 5; m < 8; m++)
        begin
            drain();
            write_reg(REG_MODE, m);
            send_event(make_event(1'b0, 32'd20 + m, 32'd8000, 32'd0, 31'd0));
            send_event(make_event(1'b1, 32'd20 + m, 32'd8001, 32'd8000, 31'd1));
        end
        drain();
        write_reg(REG_MODE, {29'd0, MODE_FIXED});
        send_event(make_event(1'b1, 32'd30, 32'd9000, 32'd8999, 31'd1));
    endtask

    // random settings per phase (extremes in the first two), random traffic
    task automatic test_random_phases();
        logic [31:0] ex;
        logic [31:0] ho;
        for (int p = 0; p < 10; p++)
        begin
            no_idle = (p % 4 == 3);
            ex = $urandom_range(5, 200);
            ho = $urandom_range(1, 300);
            if (p == 0)
                write_all(MODE_PAIMD, 32'd1, 32'd1, 31'd1, 16'd1, 32'd1, 16'd0, 16'd1);
            else if (p == 1)
                write_all(MODE_DELAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                          16'd65535, 32'hFFFF_FFFF, 16'd65535, 16'd65535);
            else
                write_all((p < 8) ? p[2:0] : 3'($urandom_range(0, 7)),
                          ($urandom_range(0, 5) == 0) ? $urandom : ex,
                          ($urandom_range(0, 5) == 0) ? $urandom : ho,
                          ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                      : 31'($urandom_range(0, 10000)),
                          16'($urandom_range(0, 65535)),
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000),
                          16'($urandom_range(0, 100)), 16'($urandom_range(0, 200)));
            for (int n = 0; n < 160; n++)
                random_event();
        end
        no_idle = 1'b0;
    endtask

    // long receiver hold-off while events keep coming, so the block backs up
    task automatic test_backpressure();
        write_all(MODE_AIMD, 32'd60, 32'd80, 31'd5205, 16'd30000, 32'd3428,
                  16'd30, 16'd70);
        hold_req = 1500;
        for (int n = 0; n < 40; n++)
            random_event();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        // predictor starts at the reset state
        cur_mode = MODE_PAIMD;
        cur_expiry = 32'd51;
        cur_holdoff = 32'd74;
        cur_modulus = 31'd5205;
        cur_factor = 16'd15073;
        cur_target = 32'd3428;
        cur_low = 16'd30;
        cur_high = 16'd70;
        win_now = RESET_WINDOW;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            slot_busy[i] = 1'b0;
        last_cut = 32'd0;
        last_adjust = 32'd0;
        now_ms = 32'd100;
        next_seq = 32'd100000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_table_full();
        test_modes_directed();
        test_random_phases();
        test_backpressure();

        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
